[hw/rtl/gcvb_pkg.sv]
// Shared types, codes and helpers for the cut-vertex and bridge finder.
// Used by graph_cut_vertex_and_bridge_finder and tb_top; no dependencies.
`default_nettype none

package gcvb_pkg;

    localparam int N_MAX = 64;                 // rows and columns of the matrix
    localparam int IDX_W = $clog2(N_MAX);      // row index
    localparam int CNT_W = $clog2(N_MAX) + 1;  // node count, may equal N_MAX
    localparam int WK_AW = IDX_W + 1;          // work memory: base and trial banks

    // Operation codes
    localparam logic [2:0] OP_INSERT      = 3'd0;
    localparam logic [2:0] OP_DELETE      = 3'd1;
    localparam logic [2:0] OP_ADD_NR      = 3'd2;
    localparam logic [2:0] OP_LIST_CUT    = 3'd3;
    localparam logic [2:0] OP_LIST_BRIDGE = 3'd4;

    // Result status codes
    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_REJECTED  = 3'd1;
    localparam logic [2:0] ST_REDUNDANT = 3'd2;
    localparam logic [2:0] ST_ADDED     = 3'd3;
    localparam logic [2:0] ST_ENTRY     = 3'd4;
    localparam logic [2:0] ST_EMPTY     = 3'd5;

    // Register addresses
    localparam logic [2:0] ADDR_NODE_COUNT = 3'd0;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_EDGE_RD,
        S_EDGE_WA,
        S_EDGE_WB,
        S_CP_RD,
        S_CP_WR,
        S_PV_RD,
        S_PV_LD,
        S_RW_RD,
        S_RW_WR,
        S_CL_DONE,
        S_CHK_RD,
        S_CHK_CK,
        S_CMP_RB,
        S_CMP_RT,
        S_CMP_CK,
        S_PUSH,
        S_NEXT,
        S_BR_RD,
        S_BR_LD,
        S_BR_SCAN,
        S_FIN,
        S_EMIT
    } t_state;

    typedef logic [N_MAX-1:0] t_row;

    // Single set bit at a column
    function automatic t_row bit_at(input logic [IDX_W-1:0] c);
        t_row r;
        r    = '0;
        r[c] = 1'b1;
        return r;
    endfunction

    // Columns below the active node count
    function automatic t_row col_mask(input logic [CNT_W-1:0] n);
        t_row r;
        for (int c = 0; c < N_MAX; c++) begin
            r[c] = (CNT_W'(c) < n);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/gcvb_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module gcvb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write, and read through an output register (old data on a clash)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[hw/rtl/graph_cut_vertex_and_bridge_finder.sv]
// Cut-vertex and bridge finder. Keeps an undirected adjacency matrix (64 rows of 64 bits,
// cleared by a pass after reset, during which no input is taken) and a work memory
// with a base and a trial closure bank. Add-if-not-redundant and both list operations
// build a reachability closure by Warshall's method over the work memory, one row visit
// at a time through its single read port. A cut-vertex list runs n + 1 closures plus a
// comparison of up to n rows for each node; a bridge list runs one trial closure per
// stored edge, found by a column-by-column scan. Results leave through an output
// register, at most 64 list entries per item.
// Depends on gcvb_pkg and gcvb_ram.
`default_nettype none

module graph_cut_vertex_and_bridge_finder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input transactions
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [2:0] opcode, [9:3] node_a, [16:10] node_b
    // result transactions
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [23:0] m_axis_tdata,   // [2:0] status, [9:3] node_x, [16:10] node_y
    output logic             m_axis_tlast,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    import gcvb_pkg::*;

    t_state r_state, n_state;

    logic [CNT_W-1:0] r_node_count;
    logic [2:0]       r_op, n_op;
    logic [IDX_W-1:0] r_a, n_a, r_b, n_b;
    logic [CNT_W-1:0] r_n, n_n;
    logic [CNT_W-1:0] r_vi, n_vi, r_vj, n_vj;
    logic [CNT_W-1:0] r_k, n_k, r_i, n_i;
    logic             r_bank, n_bank;
    t_row             r_pk, n_pk, r_tmp, n_tmp, r_row, n_row;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_pend_valid, n_pend_valid;
    logic [6:0]       r_pend_x, n_pend_x, r_pend_y, n_pend_y;
    logic [6:0]       r_nx, n_nx, r_ny, n_ny;
    logic [2:0]       r_e_status, n_e_status;
    logic             r_out_valid, n_out_valid;
    logic [2:0]       r_out_status, n_out_status;
    logic [6:0]       r_out_x, n_out_x, r_out_y, n_out_y;
    logic             r_out_last, n_out_last;

    logic             adj_we;
    logic [IDX_W-1:0] adj_waddr, adj_raddr;
    t_row             adj_wdata, adj_rdata;
    logic             wk_we;
    logic [WK_AW-1:0] wk_waddr, wk_raddr;
    t_row             wk_wdata, wk_rdata;

    logic [2:0]       in_op;
    logic [6:0]       in_a, in_b;
    logic [CNT_W-1:0] act_n;
    logic             in_bad;
    logic             slot_free;
    t_row             cp_row, cmp_d;

    gcvb_ram #(.WIDTH(N_MAX), .DEPTH(N_MAX)) u_adj (
        .i_clk  (i_clk),
        .i_we   (adj_we),
        .i_waddr(adj_waddr),
        .i_wdata(adj_wdata),
        .i_raddr(adj_raddr),
        .o_rdata(adj_rdata)
    );

    gcvb_ram #(.WIDTH(N_MAX), .DEPTH(2 * N_MAX)) u_work (
        .i_clk  (i_clk),
        .i_we   (wk_we),
        .i_waddr(wk_waddr),
        .i_wdata(wk_wdata),
        .i_raddr(wk_raddr),
        .o_rdata(wk_rdata)
    );

    // Configuration port
    assign pready = 1'b1;
    assign prdata = {{(32 - CNT_W){1'b0}}, r_node_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= CNT_W'(N_MAX);
        end else if (psel && penable && pwrite && paddr == ADDR_NODE_COUNT) begin
            r_node_count <= pwdata[CNT_W-1:0];
        end
    end

    // Input decode
    assign in_op  = s_axis_tdata[2:0];
    assign in_a   = s_axis_tdata[9:3];
    assign in_b   = s_axis_tdata[16:10];
    assign act_n  = (r_node_count > CNT_W'(N_MAX)) ? CNT_W'(N_MAX) : r_node_count;
    assign in_bad = (in_a == '0) || (in_b == '0) || (in_a > act_n) || (in_b > act_n);

    assign s_axis_tready = (r_state == S_IDLE);
    assign slot_free     = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_y, r_out_x, r_out_status};
    assign m_axis_tlast  = r_out_last;

    // Row as copied into a closure bank, with the trial removal applied
    always_comb begin
        cp_row = adj_rdata & col_mask(r_n);
        if (r_bank) begin
            if (r_op == OP_LIST_CUT) begin
                cp_row = cp_row & ~bit_at(r_vi[IDX_W-1:0]);
                if (r_i == r_vi) begin
                    cp_row = '0;
                end
            end else begin
                if (r_i == r_vi) begin
                    cp_row = cp_row & ~bit_at(r_vj[IDX_W-1:0]);
                end
                if (r_i == r_vj) begin
                    cp_row = cp_row & ~bit_at(r_vi[IDX_W-1:0]);
                end
            end
        end
    end

    // Reachability lost between two other nodes on this row
    always_comb begin
        cmp_d = (r_tmp ^ wk_rdata) & ~bit_at(r_i[IDX_W-1:0]);
        if (r_op == OP_LIST_CUT) begin
            cmp_d = cmp_d & ~bit_at(r_vi[IDX_W-1:0]);
            if (r_i == r_vi) begin
                cmp_d = '0;
            end
        end
    end

    // State and context registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
            r_cnt        <= '0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
            r_cnt        <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_a          <= n_a;
        r_b          <= n_b;
        r_n          <= n_n;
        r_vi         <= n_vi;
        r_vj         <= n_vj;
        r_k          <= n_k;
        r_i          <= n_i;
        r_bank       <= n_bank;
        r_pk         <= n_pk;
        r_tmp        <= n_tmp;
        r_row        <= n_row;
        r_pend_x     <= n_pend_x;
        r_pend_y     <= n_pend_y;
        r_nx         <= n_nx;
        r_ny         <= n_ny;
        r_e_status   <= n_e_status;
        r_out_status <= n_out_status;
        r_out_x      <= n_out_x;
        r_out_y      <= n_out_y;
        r_out_last   <= n_out_last;
    end

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_a          = r_a;
        n_b          = r_b;
        n_n          = r_n;
        n_vi         = r_vi;
        n_vj         = r_vj;
        n_k          = r_k;
        n_i          = r_i;
        n_bank       = r_bank;
        n_pk         = r_pk;
        n_tmp        = r_tmp;
        n_row        = r_row;
        n_cnt        = r_cnt;
        n_pend_valid = r_pend_valid;
        n_pend_x     = r_pend_x;
        n_pend_y     = r_pend_y;
        n_nx         = r_nx;
        n_ny         = r_ny;
        n_e_status   = r_e_status;
        n_out_status = r_out_status;
        n_out_x      = r_out_x;
        n_out_y      = r_out_y;
        n_out_last   = r_out_last;
        n_out_valid  = r_out_valid && !m_axis_tready;

        adj_we    = 1'b0;
        adj_waddr = r_a;
        adj_wdata = adj_rdata;
        adj_raddr = r_a;
        wk_we     = 1'b0;
        wk_waddr  = {r_bank, r_i[IDX_W-1:0]};
        wk_wdata  = cp_row;
        wk_raddr  = {r_bank, r_i[IDX_W-1:0]};

        case (r_state)
            // Clearing pass after reset: zero every adjacency row
            S_CLEAR: begin
                adj_we    = 1'b1;
                adj_waddr = r_cnt[IDX_W-1:0];
                adj_wdata = '0;
                if (r_cnt == CNT_W'(N_MAX - 1)) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op  = in_op;
                    n_a   = IDX_W'(in_a - 7'd1);
                    n_b   = IDX_W'(in_b - 7'd1);
                    n_n   = act_n;
                    n_cnt = '0;
                    n_i   = '0;
                    n_bank = 1'b0;
                    if (in_op == OP_INSERT || in_op == OP_DELETE || in_op == OP_ADD_NR) begin
                        if (in_bad) begin
                            n_e_status = ST_REJECTED;
                            n_state    = S_EMIT;
                        end else if (in_a == in_b) begin
                            n_e_status = (in_op == OP_ADD_NR) ? ST_ADDED : ST_DONE;
                            n_state    = S_EMIT;
                        end else if (in_op == OP_ADD_NR) begin
                            n_state = S_CP_RD;
                        end else begin
                            n_state = S_EDGE_RD;
                        end
                    end else if (in_op == OP_LIST_CUT || in_op == OP_LIST_BRIDGE) begin
                        if (act_n == '0) begin
                            n_e_status = ST_EMPTY;
                            n_state    = S_EMIT;
                        end else begin
                            n_state = S_CP_RD;
                        end
                    end else begin
                        n_e_status = ST_REJECTED;
                        n_state    = S_EMIT;
                    end
                end
            end

            // Edge update: read-modify-write of both rows
            S_EDGE_RD: begin
                adj_raddr = r_a;
                n_state   = S_EDGE_WA;
            end
            S_EDGE_WA: begin
                adj_we    = 1'b1;
                adj_waddr = r_a;
                adj_wdata = (r_op == OP_DELETE) ? (adj_rdata & ~bit_at(r_b))
                                                : (adj_rdata | bit_at(r_b));
                adj_raddr = r_b;
                n_state   = S_EDGE_WB;
            end
            S_EDGE_WB: begin
                adj_we     = 1'b1;
                adj_waddr  = r_b;
                adj_wdata  = (r_op == OP_DELETE) ? (adj_rdata & ~bit_at(r_a))
                                                 : (adj_rdata | bit_at(r_a));
                n_e_status = (r_op == OP_ADD_NR) ? ST_ADDED : ST_DONE;
                n_state    = S_EMIT;
            end

            // Copy active rows into the selected bank
            S_CP_RD: begin
                adj_raddr = r_i[IDX_W-1:0];
                n_state   = S_CP_WR;
            end
            S_CP_WR: begin
                wk_we    = 1'b1;
                wk_waddr = {r_bank, r_i[IDX_W-1:0]};
                wk_wdata = cp_row;
                if (r_i + 1'b1 == r_n) begin
                    n_k     = '0;
                    n_state = S_PV_RD;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_CP_RD;
                end
            end

            // Warshall: fetch pivot row, then fold it into each row that reaches it
            S_PV_RD: begin
                wk_raddr = {r_bank, r_k[IDX_W-1:0]};
                n_state  = S_PV_LD;
            end
            S_PV_LD: begin
                n_pk    = wk_rdata;
                n_i     = '0;
                n_state = S_RW_RD;
            end
            S_RW_RD: begin
                wk_raddr = {r_bank, r_i[IDX_W-1:0]};
                n_state  = S_RW_WR;
            end
            S_RW_WR: begin
                wk_we    = wk_rdata[r_k[IDX_W-1:0]];
                wk_waddr = {r_bank, r_i[IDX_W-1:0]};
                wk_wdata = wk_rdata | r_pk;
                if (r_i + 1'b1 == r_n) begin
                    if (r_k + 1'b1 == r_n) begin
                        n_state = S_CL_DONE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_PV_RD;
                    end
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_RW_RD;
                end
            end

            // Closure finished: pick the next step
            S_CL_DONE: begin
                n_i = '0;
                if (r_bank) begin
                    n_state = S_CMP_RB;
                end else if (r_op == OP_ADD_NR) begin
                    n_state = S_CHK_RD;
                end else if (r_op == OP_LIST_CUT) begin
                    n_vi    = '0;
                    n_bank  = 1'b1;
                    n_state = S_CP_RD;
                end else begin
                    n_vi    = '0;
                    n_bank  = 1'b1;
                    n_state = S_BR_RD;
                end
            end

            // Redundancy check against the base closure
            S_CHK_RD: begin
                wk_raddr = {1'b0, r_a};
                n_state  = S_CHK_CK;
            end
            S_CHK_CK: begin
                if (wk_rdata[r_b]) begin
                    n_e_status = ST_REDUNDANT;
                    n_state    = S_EMIT;
                end else begin
                    n_state = S_EDGE_RD;
                end
            end

            // Compare base and trial banks row by row
            S_CMP_RB: begin
                wk_raddr = {1'b0, r_i[IDX_W-1:0]};
                n_state  = S_CMP_RT;
            end
            S_CMP_RT: begin
                n_tmp    = wk_rdata;
                wk_raddr = {1'b1, r_i[IDX_W-1:0]};
                n_state  = S_CMP_CK;
            end
            S_CMP_CK: begin
                if (cmp_d != '0) begin
                    n_nx    = r_vi + 1'b1;
                    n_ny    = (r_op == OP_LIST_CUT) ? 7'd0 : (r_vj + 1'b1);
                    n_state = S_PUSH;
                end else if (r_i + 1'b1 == r_n) begin
                    n_state = S_NEXT;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_CMP_RB;
                end
            end

            // Hold the newest entry back so the final one can carry last
            S_PUSH: begin
                if (!r_pend_valid) begin
                    n_pend_valid = 1'b1;
                    n_pend_x     = r_nx;
                    n_pend_y     = r_ny;
                    n_cnt        = r_cnt + 1'b1;
                    n_state      = S_NEXT;
                end else if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_ENTRY;
                    n_out_x      = r_pend_x;
                    n_out_y      = r_pend_y;
                    n_out_last   = 1'b0;
                    n_pend_x     = r_nx;
                    n_pend_y     = r_ny;
                    n_cnt        = r_cnt + 1'b1;
                    n_state      = S_NEXT;
                end
            end

            // Advance to the next candidate node or edge
            S_NEXT: begin
                n_i = '0;
                if (r_cnt == CNT_W'(N_MAX)) begin
                    n_state = S_FIN;
                end else if (r_op == OP_LIST_CUT) begin
                    if (r_vi + 1'b1 == r_n) begin
                        n_state = S_FIN;
                    end else begin
                        n_vi    = r_vi + 1'b1;
                        n_state = S_CP_RD;
                    end
                end else begin
                    n_vj    = r_vj + 1'b1;
                    n_state = S_BR_SCAN;
                end
            end

            // Bridge candidates: stored edges (i, j) with j below i
            S_BR_RD: begin
                adj_raddr = r_vi[IDX_W-1:0];
                n_state   = S_BR_LD;
            end
            S_BR_LD: begin
                n_row   = adj_rdata;
                n_vj    = '0;
                n_state = S_BR_SCAN;
            end
            S_BR_SCAN: begin
                n_i = '0;
                if (r_vj == r_vi) begin
                    if (r_vi + 1'b1 == r_n) begin
                        n_state = S_FIN;
                    end else begin
                        n_vi    = r_vi + 1'b1;
                        n_state = S_BR_RD;
                    end
                end else if (r_row[r_vj[IDX_W-1:0]]) begin
                    n_state = S_CP_RD;
                end else begin
                    n_vj = r_vj + 1'b1;
                end
            end

            // Close a list: final entry with last, or an empty marker
            S_FIN: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_pend_valid ? ST_ENTRY : ST_EMPTY;
                    n_out_x      = r_pend_valid ? r_pend_x : 7'd0;
                    n_out_y      = r_pend_valid ? r_pend_y : 7'd0;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end

            // Single-result items
            S_EMIT: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_e_status;
                    n_out_x      = 7'd0;
                    n_out_y      = 7'd0;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Only a list entry may go out without last
    a_last_on_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_out_status != ST_ENTRY |-> m_axis_tlast)
        else $error("single result without last");

    // The adjacency matrix changes only during an edge update or the clearing pass
    a_adj_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adj_we |-> (r_state == S_EDGE_WA || r_state == S_EDGE_WB || r_state == S_CLEAR))
        else $error("adjacency written outside edge update");

    // List length never exceeds the entry limit
    a_cnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(N_MAX))
        else $error("list entry count overflow");

    // A held-back entry is always flushed before the block takes a new item
    a_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !r_pend_valid)
        else $error("pending entry left behind");

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Testbench for the cut-vertex and bridge finder: directed and random edge and list traffic,
// checked result by result against a matrix-closure predictor held in a scoreboard class.
// Depends on gcvb_pkg and the RTL of graph_cut_vertex_and_bridge_finder.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gcvb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000000;
    localparam int HOLD_CYCLES    = 2000;
    localparam int MAX_LIST       = 64;

    typedef logic [N_MAX-1:0][N_MAX-1:0] t_mat;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] node_x;
        logic [6:0] node_y;
        logic       last;
    } t_result;

    // Predictor and store of expected results
    class cut_scoreboard;
        t_mat        adj;
        int unsigned node_count;
        t_result     pending[$];
        int          errors;

        function new();
            adj        = '0;
            node_count = 64;
            errors     = 0;
        endfunction

        // Reachability closure over the first n nodes, diagonal cleared
        function t_mat reach(t_mat m, int n);
            t_row mask;
            mask = '0;
            for (int c = 0; c < n; c++) mask[c] = 1'b1;
            for (int i = 0; i < N_MAX; i++) m[i] = (i < n) ? (m[i] & mask) : '0;
            for (int k = 0; k < n; k++)
                for (int i = 0; i < n; i++)
                    if (m[i][k]) m[i] = m[i] | m[k];
            for (int i = 0; i < n; i++) m[i][i] = 1'b0;
            return m;
        endfunction

        // Reachability changed between two distinct nodes, neither being skip
        function bit reach_changed(t_mat b, t_mat t, int n, int skip);
            t_row d;
            for (int i = 0; i < n; i++) begin
                if (i == skip) continue;
                d = b[i] ^ t[i];
                for (int c = n; c < N_MAX; c++) d[c] = 1'b0;
                d[i] = 1'b0;
                if (skip < n) d[skip] = 1'b0;
                if (d != '0) return 1'b1;
            end
            return 1'b0;
        endfunction

        function void push(logic [2:0] st, int x, int y, bit last);
            t_result r;
            r.status = st;
            r.node_x = x[6:0];
            r.node_y = y[6:0];
            r.last   = last;
            pending.push_back(r);
        endfunction

        // Note an accepted input transaction and work out its results
        function void note_item(logic [2:0] op, logic [6:0] a, logic [6:0] b);
            int   n, ia, ib, cnt;
            t_mat base, trial;
            n = (node_count > N_MAX) ? N_MAX : node_count;
            if (op <= OP_ADD_NR) begin
                if (a < 1 || b < 1 || a > n || b > n) begin
                    push(ST_REJECTED, 0, 0, 1);
                    return;
                end
                ia = a - 1;
                ib = b - 1;
                if (op == OP_ADD_NR) begin
                    base = reach(adj, n);
                    if (ia != ib && base[ia][ib]) begin
                        push(ST_REDUNDANT, 0, 0, 1);
                        return;
                    end
                    if (ia != ib) begin
                        adj[ia][ib] = 1'b1;
                        adj[ib][ia] = 1'b1;
                    end
                    push(ST_ADDED, 0, 0, 1);
                    return;
                end
                if (ia != ib) begin
                    adj[ia][ib] = (op == OP_INSERT);
                    adj[ib][ia] = (op == OP_INSERT);
                end
                push(ST_DONE, 0, 0, 1);
                return;
            end
            if (op > OP_LIST_BRIDGE) begin
                push(ST_REJECTED, 0, 0, 1);
                return;
            end
            base = reach(adj, n);
            cnt  = 0;
            if (op == OP_LIST_CUT) begin
                for (int i = 0; i < n && cnt < MAX_LIST; i++) begin
                    trial    = adj;
                    trial[i] = '0;
                    for (int j = 0; j < N_MAX; j++) trial[j][i] = 1'b0;
                    trial = reach(trial, n);
                    if (reach_changed(base, trial, n, i)) begin
                        push(ST_ENTRY, i + 1, 0, 0);
                        cnt++;
                    end
                end
            end else begin
                for (int i = 0; i < n && cnt < MAX_LIST; i++)
                    for (int j = 0; j < i && cnt < MAX_LIST; j++) begin
                        if (!adj[i][j]) continue;
                        trial       = adj;
                        trial[i][j] = 1'b0;
                        trial[j][i] = 1'b0;
                        trial = reach(trial, n);
                        if (reach_changed(base, trial, n, N_MAX)) begin
                            push(ST_ENTRY, i + 1, j + 1, 0);
                            cnt++;
                        end
                    end
            end
            if (cnt == 0) push(ST_EMPTY, 0, 0, 1);
            else pending[pending.size() - 1].last = 1'b1;
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Compare an accepted result transaction with the oldest expectation
        task check(logic [23:0] data, logic last);
            t_result e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result data=%h last=%b", data, last));
                return;
            end
            e = pending.pop_front();
            if (data[2:0] !== e.status)
                report($sformatf("status %0d, expected %0d", data[2:0], e.status));
            if (data[9:3] !== e.node_x)
                report($sformatf("node_x %0d, expected %0d", data[9:3], e.node_x));
            if (data[16:10] !== e.node_y)
                report($sformatf("node_y %0d, expected %0d", data[16:10], e.node_y));
            if (last !== e.last)
                report($sformatf("tlast %b, expected %b", last, e.last));
        endtask
    endclass

    cut_scoreboard sb = new();

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [23:0] s_data  = '0;
    logic        m_ready = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;

    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [23:0] m_axis_tdata;    // [2:0] status, [9:3] node_x, [16:10] node_y
    logic        m_axis_tlast;
    logic [31:0] prdata;
    logic        pready;

    int idle_pct    = 0;
    int stall_pct   = 0;
    int hold_token  = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int quiet_count = 0;
    bit offering    = 1'b0;

    always #5 i_clk = ~i_clk;

    graph_cut_vertex_and_bridge_finder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),      // [2:0] opcode, [9:3] node_a, [16:10] node_b
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Result side: check transactions, then choose next tready (long hold-off on request)
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_ready) sb.check(m_axis_tdata, m_axis_tlast);
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_seen != hold_token) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog on cycles with no transaction on either stream
    always @(posedge i_clk) begin
        if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) begin
            quiet_count <= 0;
        end else begin
            quiet_count <= quiet_count + 1;
            if (quiet_count >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task send(logic [2:0] op, logic [6:0] a, logic [6:0] b);
        s_valid  <= 1'b1;
        s_data   <= {7'b0, b, a, op};
        offering = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(op, a, b);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            s_valid  <= 1'b0;
            offering = 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    // Stop offering and wait until every expected result has come
    task drain();
        if (offering) begin
            s_valid  <= 1'b0;
            offering = 1'b0;
        end
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    task write_node_count(int unsigned value);
        drain();
        repeat (40) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_NODE_COUNT;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.node_count = value & 32'h7f;
    endtask

    task send_random(int n);
        int         r;
        logic [2:0] op;
        r = $urandom_range(99);
        if (r < 88) begin
            if (r < 40)      op = OP_INSERT;
            else if (r < 55) op = OP_ADD_NR;
            else if (r < 72) op = OP_DELETE;
            else if (r < 80) op = OP_LIST_CUT;
            else             op = OP_LIST_BRIDGE;
            send(op, 7'($urandom_range(n, 1)), 7'($urandom_range(n, 1)));
        end else begin
            send(3'($urandom_range(7)), 7'($urandom_range(127)), 7'($urandom_range(127)));
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: small graph, every operation, rejections and self pairs
        write_node_count(8);
        send(OP_INSERT, 1, 2);
        send(OP_INSERT, 2, 3);
        send(OP_INSERT, 3, 4);
        send(OP_INSERT, 2, 5);
        send(OP_INSERT, 3, 3);
        send(OP_DELETE, 3, 3);
        send(OP_ADD_NR, 1, 4);
        send(OP_ADD_NR, 6, 7);
        send(OP_ADD_NR, 5, 5);
        send(OP_INSERT, 0, 2);
        send(OP_DELETE, 2, 9);
        send(OP_ADD_NR, 127, 127);
        send(3'd5, 7'h55, 7'h2a);
        send(3'd6, 0, 0);
        send(3'd7, 127, 127);
        send(OP_LIST_CUT, 0, 0);
        send(OP_LIST_BRIDGE, 127, 127);
        send(OP_DELETE, 6, 7);
        send(OP_DELETE, 1, 2);
        send(OP_LIST_CUT, 0, 0);
        send(OP_LIST_BRIDGE, 0, 0);

        // Large node count acting as the full matrix
        write_node_count(127);
        send(OP_INSERT, 64, 63);
        send(OP_ADD_NR, 63, 1);
        send(OP_ADD_NR, 1, 64);
        send(OP_INSERT, 65, 1);
        send(OP_LIST_BRIDGE, 0, 0);
        send(OP_DELETE, 1, 63);

        // Full node count: one long cut-vertex list
        write_node_count(64);
        send(OP_INSERT, 64, 1);
        send(OP_LIST_CUT, 0, 0);

        // Zero, one and three active nodes; stored edges beyond the count ignored
        write_node_count(0);
        send(OP_INSERT, 1, 1);
        send(OP_LIST_CUT, 0, 0);
        send(OP_LIST_BRIDGE, 0, 0);
        write_node_count(1);
        send(OP_INSERT, 1, 1);
        send(OP_ADD_NR, 1, 1);
        send(OP_INSERT, 1, 2);
        send(OP_LIST_CUT, 0, 0);
        send(OP_LIST_BRIDGE, 0, 0);
        write_node_count(3);
        send(OP_LIST_CUT, 0, 0);
        send(OP_LIST_BRIDGE, 0, 0);

        // Random traffic over the idling phases
        for (int ph = 0; ph < 4; ph++) begin
            write_node_count($urandom_range(10, 4));
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 79; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 79; end
                default: begin idle_pct = 34; stall_pct = 34; end
            endcase
            repeat (21) send_random(sb.node_count);
        end

        // Receiver holds off while the sender keeps offering edge updates
        idle_pct  = 0;
        stall_pct = 0;
        drain();
        hold_token = hold_token + 1;
        repeat (15) send($urandom_range(1) ? OP_INSERT : OP_DELETE,
                         7'($urandom_range(sb.node_count, 1)),
                         7'($urandom_range(sb.node_count, 1)));
        send(OP_LIST_BRIDGE, 0, 0);

        drain();
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
hw/rtl/gcvb_pkg.sv
hw/rtl/gcvb_ram.sv
hw/rtl/graph_cut_vertex_and_bridge_finder.sv
sim/tb_top.sv
